// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every rising clock edge outside reset.
`define CHK_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dsa_pkg.sv =====
package dsa_pkg;

	localparam int OP_W   = 2;
	localparam int CNT_W  = 11;
	localparam int SLOT_W = 10;
	localparam int CAP_W  = 11;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic              valid;
		logic              ok;
		logic [SLOT_W-1:0] first;
	} dsa_res_t;

endpackage

// ===== rtl/dsa_ram.sv =====
module dsa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/dsa_core.sv =====
module dsa_core #(
	parameter int SLOTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dsa_pkg::CAP_W-1:0]   capacity,
	input  logic                        cfg_we,
	input  logic                        start_op,
	input  logic [dsa_pkg::OP_W-1:0]    operation,
	input  logic [dsa_pkg::CNT_W-1:0]   count,
	input  logic [dsa_pkg::SLOT_W-1:0]  slot,
	output logic                        ready,
	output dsa_pkg::dsa_res_t           res,
	input  logic                        res_take
);
	import dsa_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int NW = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DISP, S_POP, S_SCAN_RD, S_SCAN_CHK, S_MARK,
		S_CMP_RD, S_CMP_CHK, S_LOOK_CHK, S_RESP
	} state_t;

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] slot_q;
	logic [NW-1:0]     hw_q, depth_q, i_q, run_q, k_q, start_q, end_q;
	logic              ok_q;
	logic [SLOT_W-1:0] first_q;

	logic [NW-1:0]     pool_n, depth_m1, i_p1, run_nx;
	logic              scan_free, v_keep, slot_alloc;

	logic              map_we, map_wdata, map_rdata;
	logic [SW-1:0]     map_waddr, map_raddr;
	logic              stk_we;
	logic [SW-1:0]     stk_waddr, stk_raddr, stk_wdata, stk_rdata;

	assign pool_n    = (32'(capacity) > SLOTS) ? NW'(SLOTS) : NW'(capacity);
	assign depth_m1  = depth_q - 1'b1;
	assign i_p1      = i_q + 1'b1;
	assign scan_free = (i_q >= hw_q) || !map_rdata;
	assign run_nx    = scan_free ? run_q + 1'b1 : '0;
	assign v_keep    = (NW'(stk_rdata) < start_q) || (NW'(stk_rdata) >= end_q);
	assign slot_alloc = (32'(slot_q) < 32'(hw_q)) && (32'(slot_q) < 32'(pool_n)) && map_rdata;

	// memory port steering by sequencer state
	always_comb begin
		map_we    = 1'b0;
		map_wdata = 1'b0;
		map_waddr = i_q[SW-1:0];
		map_raddr = i_q[SW-1:0];
		stk_we    = 1'b0;
		stk_waddr = k_q[SW-1:0];
		stk_wdata = stk_rdata;
		stk_raddr = i_q[SW-1:0];
		case (state_q)
			S_CLR: begin
				map_we = 1'b1;
			end
			S_DISP: begin
				map_raddr = SW'(slot_q);
				stk_raddr = depth_m1[SW-1:0];
				if (op_q == OP_ALLOC && cnt_q == CNT_W'(1) && pool_n != '0 &&
				    depth_q == '0 && hw_q < pool_n) begin
					map_we    = 1'b1;
					map_wdata = 1'b1;
					map_waddr = hw_q[SW-1:0];
				end
			end
			S_POP: begin
				map_we    = 1'b1;
				map_wdata = 1'b1;
				map_waddr = stk_rdata;
			end
			S_MARK: begin
				map_we    = 1'b1;
				map_wdata = 1'b1;
			end
			S_CMP_CHK: begin
				stk_we = v_keep;
			end
			S_LOOK_CHK: begin
				if (op_q == OP_FREE && slot_alloc && 32'(depth_q) < SLOTS) begin
					map_we    = 1'b1;
					map_waddr = SW'(slot_q);
					stk_we    = 1'b1;
					stk_waddr = depth_q[SW-1:0];
					stk_wdata = SW'(slot_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			i_q     <= '0;
			hw_q    <= '0;
			depth_q <= '0;
		end else if (cfg_we) begin
			state_q <= S_CLR;
			i_q     <= '0;
			hw_q    <= '0;
			depth_q <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					i_q <= i_p1;
					if (32'(i_q) == SLOTS - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start_op) begin
						op_q    <= operation;
						cnt_q   <= count;
						slot_q  <= slot;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					ok_q    <= 1'b0;
					first_q <= '0;
					state_q <= S_RESP;
					if (op_q == OP_ALLOC) begin
						if (cnt_q == '0 || pool_n == '0) begin
							state_q <= S_RESP;
						end else if (cnt_q == CNT_W'(1)) begin
							if (depth_q != '0) begin
								state_q <= S_POP;
							end else if (hw_q < pool_n) begin
								hw_q    <= hw_q + 1'b1;
								ok_q    <= 1'b1;
								first_q <= SLOT_W'(hw_q);
							end
						end else if (32'(cnt_q) <= 32'(pool_n)) begin
							i_q     <= '0;
							run_q   <= '0;
							state_q <= S_SCAN_RD;
						end
					end else if (op_q == OP_FREE || op_q == OP_QUERY) begin
						state_q <= S_LOOK_CHK;
					end
				end
				S_POP: begin
					depth_q <= depth_m1;
					ok_q    <= 1'b1;
					first_q <= SLOT_W'(stk_rdata);
					state_q <= S_RESP;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					run_q <= run_nx;
					if (32'(run_nx) == 32'(cnt_q)) begin
						// run ends at i: start = i + 1 - count
						start_q <= NW'(32'(i_q) + 1 - 32'(cnt_q));
						i_q     <= NW'(32'(i_q) + 1 - 32'(cnt_q));
						end_q   <= i_p1;
						state_q <= S_MARK;
					end else if (i_p1 == pool_n) begin
						state_q <= S_RESP;
					end else begin
						i_q     <= i_p1;
						state_q <= S_SCAN_RD;
					end
				end
				S_MARK: begin
					if (i_p1 == end_q) begin
						i_q     <= '0;
						k_q     <= '0;
						state_q <= S_CMP_RD;
					end else begin
						i_q <= i_p1;
					end
				end
				S_CMP_RD: begin
					if (i_q == depth_q) begin
						depth_q <= k_q;
						if (hw_q < end_q) begin
							hw_q <= end_q;
						end
						ok_q    <= 1'b1;
						first_q <= SLOT_W'(start_q);
						state_q <= S_RESP;
					end else begin
						state_q <= S_CMP_CHK;
					end
				end
				S_CMP_CHK: begin
					if (v_keep) begin
						k_q <= k_q + 1'b1;
					end
					i_q     <= i_p1;
					state_q <= S_CMP_RD;
				end
				S_LOOK_CHK: begin
					if (op_q == OP_FREE) begin
						if (slot_alloc && 32'(depth_q) < SLOTS) begin
							depth_q <= depth_q + 1'b1;
							ok_q    <= 1'b1;
						end
					end else begin
						ok_q <= slot_alloc;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	dsa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	dsa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_stk (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign ready     = (state_q == S_IDLE);
	assign res.valid = (state_q == S_RESP);
	assign res.ok    = ok_q;
	assign res.first = first_q;

endmodule

// ===== rtl/descriptor_slot_allocator.sv =====
// channel   | handshake           | payload
// ----------+---------------------+-----------------------------
// in        | in_valid / in_stall | operation, count, slot
// out       | out_valid/out_stall | ok, first_slot
// capacity  | capacity_we         | capacity_wdata
//
// One transaction at a time.
// Range allocate scans the bitmap slot by slot, marks each slot of the run found, then
// compacts the freed-stack entries; reads of the bitmap and stack RAM are registered.
// After reset and every capacity write a pass clears all SLOTS bitmap entries; in_stall is high.
// The result register frees the sequencer while out_stall is held only if it is empty.
module descriptor_slot_allocator #(
	parameter int SLOTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        capacity_we,
	input  logic [dsa_pkg::CAP_W-1:0]   capacity_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [dsa_pkg::OP_W-1:0]    operation,
	input  logic [dsa_pkg::CNT_W-1:0]   count,
	input  logic [dsa_pkg::SLOT_W-1:0]  slot,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic [dsa_pkg::SLOT_W-1:0]  first_slot
);
	import dsa_pkg::*;

	logic [CAP_W-1:0]  capacity_q;
	logic              core_ready, res_take;
	dsa_res_t          res;
	logic              out_valid_q, ok_q;
	logic [SLOT_W-1:0] first_q;

	assign in_stall = !core_ready;
	assign res_take = res.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (capacity_we) begin
				capacity_q <= capacity_wdata;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			ok_q    <= res.ok;
			first_q <= res.first;
		end
	end

	dsa_core #(.SLOTS(SLOTS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.cfg_we    (capacity_we),
		.start_op  (in_valid && core_ready),
		.operation (operation),
		.count     (count),
		.slot      (slot),
		.ready     (core_ready),
		.res       (res),
		.res_take  (res_take)
	);

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign first_slot = first_q;

endmodule

// ===== rtl/dsa_checker.sv =====
`include "assert_macros.svh"

module dsa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        capacity_we,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        ok,
	input logic [dsa_pkg::SLOT_W-1:0]  first_slot
);

	// a failed or non-allocate transaction reports slot zero
	`CHK_ALWAYS(a_fail_zero, !(out_valid && !ok) || first_slot == '0, "first_slot set without ok")
	`CHK_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "accepted while busy")
	`CHK_NEXT(a_clear_after_cfg, capacity_we, in_stall, "no clearing pass after capacity write")
	`CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(first_slot) && $stable(ok), "stalled result changed")

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dsa_pkg::*;

	localparam int SLOTS = 1024;
	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [CNT_W-1:0]  cnt;
		logic [SLOT_W-1:0] slt;
	} request_t;

	typedef struct {
		logic              ok;
		logic [SLOT_W-1:0] first;
	} grant_t;

	logic                clk;
	logic                arst_n;
	logic                capacity_we;
	logic [CAP_W-1:0]    capacity_wdata;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     operation;
	logic [CNT_W-1:0]    count;
	logic [SLOT_W-1:0]   slot;
	logic                out_valid;
	logic                out_stall;
	logic                ok;
	logic [SLOT_W-1:0]   first_slot;
	logic                stall_pattern;
	logic                hold_off;

	request_t pending_reqs[$];
	grant_t   expected_grants[$];
	int       err_cnt;
	int       accepted_cnt;
	logic     taken;
	int       burst_left;
	int       gap_left;

	// shadow of the allocator
	bit                in_use[SLOTS];
	logic [SLOT_W-1:0] freed[SLOTS];
	int                freed_top;
	int                mark;
	int                cap_reg;

	descriptor_slot_allocator #(.SLOTS(SLOTS)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.capacity_we   (capacity_we),
		.capacity_wdata(capacity_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.count         (count),
		.slot          (slot),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.first_slot    (first_slot)
	);

	assign out_stall = stall_pattern | hold_off;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int pool_slots();
		return (cap_reg > SLOTS) ? SLOTS : cap_reg;
	endfunction

	function automatic bit held(int s);
		return s < mark && s < pool_slots() && in_use[s];
	endfunction

	function automatic void clear_shadow();
		foreach (in_use[i])
			in_use[i] = 1'b0;
		freed_top = 0;
		mark = 0;
	endfunction

	function automatic void grant_single(output grant_t g);
		int n;
		int s;
		n = pool_slots();
		g = '{1'b0, '0};
		if (n == 0)
			return;
		if (freed_top > 0) begin
			freed_top--;
			s = int'(freed[freed_top]);
			in_use[s] = 1'b1;
			g = '{1'b1, SLOT_W'(s)};
			return;
		end
		if (mark >= n)
			return;
		s = mark;
		mark++;
		in_use[s] = 1'b1;
		g = '{1'b1, SLOT_W'(s)};
	endfunction

	function automatic void grant_run(int want, output grant_t g);
		int n;
		int run;
		int start;
		int stop;
		int k;
		bit found;
		n = pool_slots();
		g = '{1'b0, '0};
		run = 0;
		start = 0;
		found = 1'b0;
		if (n == 0 || want > n)
			return;
		for (int i = 0; i < n; i++) begin
			if (i >= mark || !in_use[i])
				run++;
			else
				run = 0;
			if (run == want) begin
				start = i + 1 - want;
				found = 1'b1;
				break;
			end
		end
		if (!found)
			return;
		stop = start + want;
		for (int i = start; i < stop; i++)
			in_use[i] = 1'b1;
		// drop granted slots from the freed stack, keep order of the rest
		k = 0;
		for (int i = 0; i < freed_top; i++) begin
			if (int'(freed[i]) < start || int'(freed[i]) >= stop) begin
				freed[k] = freed[i];
				k++;
			end
		end
		freed_top = k;
		if (mark < stop)
			mark = stop;
		g = '{1'b1, SLOT_W'(start)};
	endfunction

	function automatic grant_t predict_grant(request_t r);
		grant_t g;
		g = '{1'b0, '0};
		case (r.op)
			OP_ALLOC: begin
				if (r.cnt == 1)
					grant_single(g);
				else if (r.cnt > 1)
					grant_run(int'(r.cnt), g);
			end
			OP_FREE: begin
				if (held(int'(r.slt)) && freed_top < SLOTS) begin
					freed[freed_top] = r.slt;
					freed_top++;
					in_use[r.slt] = 1'b0;
					g.ok = 1'b1;
				end
			end
			OP_QUERY: g.ok = held(int'(r.slt));
			default: ;
		endcase
		return g;
	endfunction

	task automatic report(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	// input acceptance, prediction and result checking
	always @(posedge clk) begin
		grant_t g;
		grant_t want_g;
		request_t r;
		taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			r = '{operation, count, slot};
			want_g = predict_grant(r);
			expected_grants.insert(expected_grants.size(), want_g);
			accepted_cnt++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_grants.size() == 0) begin
				report("unexpected transaction ok", int'(ok), 0);
			end else begin
				g = expected_grants.pop_front();
				if (ok !== g.ok)
					report("ok", int'(ok), int'(g.ok));
				if (first_slot !== g.first)
					report("first_slot", int'(first_slot), int'(g.first));
			end
		end
	end

	// sender: bursts with random gaps
	always @(negedge clk) begin
		request_t r;
		if (arst_n && !(in_valid && !taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				in_valid  <= 1'b1;
				operation <= r.op;
				count     <= r.cnt;
				slot      <= r.slt;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall density switches among three random modes over the run
	always @(negedge clk) begin
		int cyc;
		int mode;
		if (cyc % 64 == 0)
			mode = $urandom_range(0, 2);
		cyc++;
		case (mode)
			0: stall_pattern <= 1'b0;
			1: stall_pattern <= ($urandom_range(0, 1) == 0);
			default: stall_pattern <= ($urandom_range(0, 4) != 0);
		endcase
	end

	// one long hold-off so the block backs up into its input
	initial begin
		hold_off = 1'b0;
		wait (accepted_cnt >= 300);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (400) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#200ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void add(logic [OP_W-1:0] op, int cnt, int s);
		request_t r;
		r = '{op, CNT_W'(cnt), SLOT_W'(s)};
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || in_valid || expected_grants.size() > 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_capacity(int value);
		wait_idle();
		capacity_we    <= 1'b1;
		capacity_wdata <= CAP_W'(value);
		@(negedge clk);
		capacity_we <= 1'b0;
		cap_reg = value;
		clear_shadow();
	endtask

	task automatic random_phase(int n);
		int lim;
		int roll;
		lim = (pool_slots() > 0) ? pool_slots() + 2 : 8;
		if (lim > SLOTS)
			lim = SLOTS;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 35)
				add(OP_ALLOC, 1, $urandom_range(0, 1023));
			else if (roll < 45)
				add(OP_ALLOC, $urandom_range(2, 6), $urandom_range(0, 1023));
			else if (roll < 48)
				add(OP_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 1023));
			else if (roll < 75)
				add(OP_FREE, $urandom_range(0, 2047), $urandom_range(0, lim - 1));
			else if (roll < 93)
				add(OP_QUERY, $urandom_range(0, 2047), $urandom_range(0, lim - 1));
			else if (roll < 97)
				add(($urandom_range(0, 1) == 0) ? OP_FREE : OP_QUERY,
				    $urandom_range(0, 2047), $urandom_range(0, 1023));
			else
				add(OP_UNKNOWN, $urandom_range(0, 2047), $urandom_range(0, 1023));
		end
	endtask

	initial begin
		int caps[7];
		caps           = '{16, 3, 64, 1024, 2047, 200, 7};
		arst_n         = 1'b0;
		capacity_we    = 1'b0;
		capacity_wdata = '0;
		in_valid       = 1'b0;
		operation      = OP_ALLOC;
		count          = '0;
		slot           = '0;
		stall_pattern  = 1'b0;
		err_cnt        = 0;
		accepted_cnt   = 0;
		burst_left     = 0;
		gap_left       = 0;
		cap_reg        = 0;
		clear_shadow();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// disabled pool after reset
		add(OP_ALLOC, 1, 0);
		add(OP_ALLOC, 4, 0);
		add(OP_FREE, 0, 0);
		add(OP_QUERY, 0, 0);

		write_capacity(8);
		add(OP_ALLOC, 0, 0);
		add(OP_ALLOC, 1, 0);
		add(OP_ALLOC, 1, 0);
		add(OP_ALLOC, 1, 0);
		add(OP_FREE, 0, 1);
		add(OP_FREE, 0, 0);
		add(OP_ALLOC, 1, 0);         // pops freed stack
		add(OP_FREE, 0, 1);
		add(OP_ALLOC, 3, 0);         // run above the mark, freed slot stays on the stack
		add(OP_QUERY, 0, 0);
		add(OP_QUERY, 2047, 1023);
		add(OP_FREE, 2047, 1023);
		add(OP_FREE, 0, 7);          // above mark
		add(OP_UNKNOWN, 2047, 1023);
		add(OP_ALLOC, 1024, 0);
		add(OP_ALLOC, 2047, 0);
		add(OP_ALLOC, 3, 0);
		add(OP_ALLOC, 1, 0);
		add(OP_ALLOC, 1, 0);         // allocates slot 6 at the mark
		add(OP_ALLOC, 2, 0);

		write_capacity(1024);
		add(OP_ALLOC, 1024, 0);
		add(OP_QUERY, 0, 1023);
		add(OP_ALLOC, 1, 0);

		foreach (caps[i]) begin
			write_capacity(caps[i]);
			random_phase(125);
		end

		write_capacity(0);
		random_phase(20);

		wait_idle();
		repeat (200) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/dsa_pkg.sv
rtl/dsa_ram.sv
rtl/dsa_core.sv
rtl/descriptor_slot_allocator.sv
rtl/dsa_checker.sv
tb/tb_top.sv
